// File: hdl/vdm_pkg.sv
// Shared types and constants for the vector distance block.
package vdm_pkg;

  localparam int DIST_BITS  = 48;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [1:0] {
    METRIC_EUCLID  = 2'd0,
    METRIC_SQUARED = 2'd1,
    METRIC_CITY    = 2'd2,
    METRIC_CHEBY   = 2'd3
  } metric_t;

  localparam logic REG_METRIC = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_OUT
  } vdm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: hdl/vdm_if.sv
// Valid/ready channel interfaces for element pairs and distance results.
interface vdm_pair_if #(
  parameter int ELEMENT_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [ELEMENT_BITS-1:0] elem_a;
  logic signed [ELEMENT_BITS-1:0] elem_b;
  logic                           last_elem;

  modport source (output valid, elem_a, elem_b, last_elem, input ready);
  modport sink   (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface vdm_result_if;
  import vdm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic                 saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

// File: hdl/vdm_mul.sv
// Shift-add multiplier that squares a magnitude, one partial product per cycle.
module vdm_mul #(
  parameter int MAG_BITS = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [MAG_BITS-1:0]     mag,
  output logic [2*MAG_BITS-1:0]   prod,
  output vdm_pkg::unit_stat_t     stat
);
  import vdm_pkg::*;

  localparam int PW    = 2 * MAG_BITS;
  localparam int CNT_W = $clog2(MAG_BITS + 1);

  logic [PW-1:0]       mcand;
  logic [MAG_BITS-1:0] mplier;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(MAG_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= PW'(mag);
      mplier <= mag;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hdl/vdm_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module vdm_isqrt #(
  parameter int ACC_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ACC_BITS-1:0] radicand,
  output logic [ACC_BITS-1:0] root,
  output vdm_pkg::unit_stat_t stat
);
  import vdm_pkg::*;

  localparam int STEPS = (ACC_BITS + 1) / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [ACC_BITS-1:0] rem;
  logic [ACC_BITS-1:0] onebit;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [ACC_BITS:0]   trial;
  logic                fits;

  assign trial = {1'b0, root} + {1'b0, onebit};
  assign fits  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= radicand;
      root   <= '0;
      onebit <= ACC_BITS'(1) << (2 * (STEPS - 1));
    end else if (busy) begin
      if (fits) begin
        rem  <= rem - ACC_BITS'(trial);
        root <= (root >> 1) + onebit;
      end else begin
        root <= root >> 1;
      end
      onebit <= onebit >> 2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hdl/vector_distance_metric.sv
// Distance between two streamed vectors: one element pair per transfer, result after the
// last pair. Metric 0 gives the floor square root of the sum of squared differences,
// 1 the sum itself, 2 the sum of absolute differences and 3 the largest one; the sum
// clamps at its maximum and flags it. Under metric 0 or 1 each pair first passes the
// shift-add multiplier, which squares the difference one bit per cycle; under metric 2 or 3
// the magnitude goes straight to the accumulator. After the last pair the result is
// presented, under metric 0 once the bitwise square root is done. The block takes one
// pair at a time and holds ready low until the pair, and its result if any, is done.
module vector_distance_metric #(
  parameter int ELEMENT_BITS     = 16,
  parameter int ACCUMULATOR_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  vdm_pair_if.sink                        pair,
  vdm_result_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vdm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [vdm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [vdm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import vdm_pkg::*;

  localparam int AB = ACCUMULATOR_BITS;
  localparam int MB = ELEMENT_BITS + 1;
  localparam int SB = 2 * MB;
  localparam int W  = ((SB > AB) ? SB : AB) + 1;
  localparam int VW = ((AB > DIST_BITS) ? AB : DIST_BITS) + 1;
  localparam logic [AB-1:0] ACC_MAX = {AB{1'b1}};

  vdm_state_t           state;
  vdm_state_t           state_next;
  metric_t              metric;
  metric_t              metric_r;
  logic                 last_r;
  logic [MB-1:0]        mag_r;
  logic [AB-1:0]        acc;
  logic [AB-1:0]        acc_next;
  logic                 ovf;
  logic                 ovf_next;
  logic [DIST_BITS-1:0] dist_r;
  logic                 sat_r;

  logic signed [MB-1:0] diff;
  logic [MB-1:0]        mag;
  logic                 accept;
  logic                 cfg_write;

  logic                 mul_start;
  logic [SB-1:0]        prod;
  unit_stat_t           mul_stat;
  logic                 sqrt_start;
  logic [AB-1:0]        root;
  unit_stat_t           sqrt_stat;

  logic [W-1:0]         term;
  logic [W-1:0]         sum;
  logic [W-1:0]         mag_w;
  logic                 load_out;
  logic [AB-1:0]        out_src;
  logic                 out_ovf;
  logic [VW-1:0]        out_ext;
  logic                 out_big;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_METRIC) ? APB_DATA_W'(metric) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_EUCLID;
    end else if (cfg_write && paddr[2] == REG_METRIC) begin
      metric <= metric_t'(pwdata[1:0]);
    end
  end

  // element difference magnitude
  assign diff   = MB'(pair.elem_a) - MB'(pair.elem_b);
  assign mag    = diff[MB-1] ? MB'(-diff) : MB'(diff);
  assign accept = pair.valid && pair.ready;

  assign pair.ready = (state == ST_IDLE);

  assign mul_start = accept && (metric == METRIC_EUCLID || metric == METRIC_SQUARED);

  vdm_mul #(.MAG_BITS(MB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mag   (mag),
    .prod  (prod),
    .stat  (mul_stat)
  );

  // accumulator update for the captured pair
  assign term  = (metric_r == METRIC_EUCLID || metric_r == METRIC_SQUARED) ?
                 W'(prod) : W'(mag_r);
  assign sum   = W'(acc) + term;
  assign mag_w = W'(mag_r);

  always_comb begin
    acc_next = acc;
    ovf_next = ovf;
    case (metric_r)
      METRIC_CHEBY: begin
        if (mag_w > W'(acc)) begin
          if (|mag_w[W-1:AB]) begin
            acc_next = ACC_MAX;
            ovf_next = 1'b1;
          end else begin
            acc_next = AB'(mag_w);
          end
        end
      end
      default: begin
        if (|sum[W-1:AB]) begin
          acc_next = ACC_MAX;
          ovf_next = 1'b1;
        end else begin
          acc_next = AB'(sum);
        end
      end
    endcase
  end

  assign sqrt_start = (state == ST_ACC) && last_r && (metric_r == METRIC_EUCLID);

  vdm_isqrt #(.ACC_BITS(AB)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (acc_next),
    .root     (root),
    .stat     (sqrt_stat)
  );

  // result clamp to the distance field
  assign out_src = (state == ST_SQRT) ? root : acc_next;
  assign out_ovf = (state == ST_SQRT) ? ovf : ovf_next;
  assign out_ext = VW'(out_src);
  assign out_big = |out_ext[VW-1:DIST_BITS];

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = mul_start ? ST_MUL : ST_ACC;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!last_r) begin
          state_next = ST_IDLE;
        end else if (metric_r == METRIC_EUCLID) begin
          state_next = ST_SQRT;
        end else begin
          load_out   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_SQRT: begin
        if (sqrt_stat.done) begin
          load_out   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      ovf <= 1'b0;
    end else if (state == ST_ACC) begin
      // drop the vector state once its last pair is in; hold the flag for the root
      acc <= last_r ? '0 : acc_next;
      ovf <= (last_r && metric_r != METRIC_EUCLID) ? 1'b0 : ovf_next;
    end else if (load_out) begin
      ovf <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      metric_r <= metric;
      last_r   <= pair.last_elem;
      mag_r    <= mag;
    end
    if (load_out) begin
      dist_r <= out_big ? {DIST_BITS{1'b1}} : DIST_BITS'(out_ext);
      sat_r  <= out_ovf || out_big;
    end
  end

  assign result.valid     = (state == ST_OUT);
  assign result.distance  = dist_r;
  assign result.saturated = sat_r;

  a_no_pair_while_result: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !pair.ready)
    else $error("pair accepted while a result is pending");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_MUL))
    else $error("multiplier finished outside the multiply state");

  a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done |-> (state == ST_SQRT))
    else $error("square root finished outside the root state");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (acc == '0 && !ovf))
    else $error("accumulator not cleared after the last pair");

endmodule

// File: tb/vector_distance_metric_test.sv
// Self-checking bench for the vector distance block: queued pairs, shadow predictor, scoreboard.
module vector_distance_metric_test;
  import vdm_pkg::*;

  localparam int ELEM_W = 16;
  localparam int SUM_W = 48;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;
  localparam logic [APB_ADDR_W-1:0] METRIC_ADDR = APB_ADDR_W'(4 * REG_METRIC);
  // covers the slowest pair (square), the result and the square root, with slack
  localparam int SETTLE_CYCLES = ELEM_W + 4 + 1 + (SUM_W + 1) / 2 + 1 + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     last;
  } elem_pair_t;

  typedef struct {
    logic [DIST_BITS-1:0] distance;
    logic                 saturated;
  } distance_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  vdm_pair_if #(.ELEMENT_BITS(ELEM_W)) pair_ch ();
  vdm_result_if result_ch ();

  vector_distance_metric #(
    .ELEMENT_BITS    (ELEM_W),
    .ACCUMULATOR_BITS(SUM_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  elem_pair_t pending[$];
  distance_t  distance_due[$];
  elem_pair_t on_bus;

  // shadow of the block's running state and register
  metric_t         run_metric;
  longint unsigned run_sum;
  bit              run_clamped;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_armed;
  bit  hold_served;
  int  hold_left;
  int  quiet_cycles;
  int  mismatches;
  int  pairs_taken;
  int  distances_checked;
  int  clamped_checked;

  always #5 clk = ~clk;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Fold one accepted pair into the shadow state; queue a distance on the last pair.
  function automatic void fold_pair(elem_pair_t p);
    longint          diff;
    longint unsigned mag;
    longint unsigned term;
    longint unsigned root;
    longint unsigned trial;
    distance_t       out;
    diff = longint'($signed(p.a)) - longint'($signed(p.b));
    mag = (diff < 0) ? -diff : diff;
    if (run_metric == METRIC_CHEBY) begin
      if (mag > run_sum) run_sum = mag;
    end else begin
      term = (run_metric == METRIC_CITY) ? mag : mag * mag;
      if (term > SUM_MAX - run_sum) begin
        run_sum = SUM_MAX;
        run_clamped = 1'b1;
      end else begin
        run_sum += term;
      end
    end
    if (!p.last) return;
    root = run_sum;
    if (run_metric == METRIC_EUCLID) begin
      root = 0;
      for (int k = 31; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (trial * trial <= run_sum) root = trial;
      end
    end
    out.distance = root[DIST_BITS-1:0];
    out.saturated = run_clamped;
    distance_due.push_back(out);
    run_sum = 0;
    run_clamped = 1'b0;
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return ELEM_W'($urandom_range(31) - 16);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic offer(int a, int b, bit last);
    elem_pair_t p;
    p.a = a[ELEM_W-1:0];
    p.b = b[ELEM_W-1:0];
    p.last = last;
    pending.push_back(p);
  endtask

  // Mostly well-formed vectors with random content; some stray last flags.
  task automatic queue_vectors(int count);
    elem_pair_t p;
    int left;
    left = 0;
    repeat (count) begin
      if (left == 0) left = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
      p.a = pick_elem();
      p.b = pick_elem();
      left--;
      p.last = (left == 0);
      if ($urandom_range(99) < 12) p.last = $urandom_range(1);
      if (p.last) left = 0;
      pending.push_back(p);
    end
  endtask

  // Wait until every pair is in and every distance is out, then let the block go quiet.
  task automatic settle();
    while (pending.size() != 0 || pair_ch.valid || distance_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_metric(metric_t m);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= METRIC_ADDR;
    // upper bits are don't-care; scramble them
    pwdata <= (APB_DATA_W'($urandom) & ~APB_DATA_W'(3)) | APB_DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    run_metric = m;
  endtask

  always @(posedge clk) begin : drive_pairs
    if (rst) begin
      pair_ch.valid <= 1'b0;
    end else begin
      if (pair_ch.valid && pair_ch.ready) begin
        fold_pair(on_bus);
        pairs_taken++;
      end
      if (!pair_ch.valid || pair_ch.ready) begin
        if (pending.size() != 0 &&
            !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
          on_bus = pending.pop_front();
          pair_ch.elem_a <= on_bus.a;
          pair_ch.elem_b <= on_bus.b;
          pair_ch.last_elem <= on_bus.last;
          pair_ch.valid <= 1'b1;
        end else begin
          pair_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_distances
    distance_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (distance_due.size() == 0) begin
          report_mismatch($sformatf("distance %0d with nothing pending", result_ch.distance));
        end else begin
          want = distance_due.pop_front();
          distances_checked++;
          if (want.saturated) clamped_checked++;
          if (result_ch.distance !== want.distance)
            report_mismatch($sformatf("distance %0d, want %0d", result_ch.distance,
                                      want.distance));
          if (result_ch.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, want %b", result_ch.saturated,
                                      want.saturated));
        end
      end
      if (hold_armed && !hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst) begin
      quiet_cycles = 0;
    end else if ((pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, %0d distances still pending", quiet_cycles,
                 distance_due.size());
        $display("vector_distance_metric_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pair_ch.valid = 1'b0;
    pair_ch.elem_a = '0;
    pair_ch.elem_b = '0;
    pair_ch.last_elem = 1'b0;
    result_ch.ready = 1'b0;
    run_metric = METRIC_EUCLID;
    run_sum = 0;
    run_clamped = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b0;
    hold_served = 1'b0;
    hold_left = 0;
    mismatches = 0;
    pairs_taken = 0;
    distances_checked = 0;
    clamped_checked = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset metric: single-pair vectors at the extremes, zero, and a short vector
    offer(32767, -32768, 1);
    offer(-32768, 32767, 1);
    offer(0, 0, 1);
    offer(100, -100, 0);
    offer(-1, 1, 0);
    offer(16'h1234, 16'h0FFF, 1);
    settle();
    write_metric(METRIC_SQUARED);
    offer(32767, -32768, 1);
    offer(5, 3, 0);
    offer(7, -7, 1);
    settle();
    write_metric(METRIC_CITY);
    offer(32767, -32768, 0);
    offer(-32768, 32767, 1);
    offer(1, 0, 1);
    settle();
    write_metric(METRIC_CHEBY);
    offer(-5, 10, 0);
    offer(3, 3, 0);
    offer(-32768, 32767, 0);
    offer(0, 1, 1);
    settle();
    // switch metric twice inside one open vector
    offer(1000, 0, 0);
    settle();
    write_metric(METRIC_CITY);
    offer(10, 0, 0);
    settle();
    write_metric(METRIC_EUCLID);
    offer(3, 4, 1);
    settle();

    // random vectors: no idling, sender idle, receiver stall, both
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      write_metric(seg < 4 ? metric_t'(seg) : metric_t'($urandom_range(3)));
      // long output hold while pairs are still queued
      if (seg == 1) hold_armed = 1'b1;
      queue_vectors(200);
      settle();
    end

    // close under metric 0 with a lone extreme pair and a small one
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_metric(METRIC_EUCLID);
    offer(32767, -32768, 1);
    offer(1, -1, 1);
    settle();

    $display("%0d element pairs sent, %0d distances checked, %0d of them clamped", pairs_taken,
             distances_checked, clamped_checked);
    $display("all four metrics, mid-vector metric changes, idle and stall phases, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("vector_distance_metric_test OK");
    end else begin
      $display("vector_distance_metric_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/vdm_pkg.sv
hdl/vdm_if.sv
hdl/vdm_mul.sv
hdl/vdm_isqrt.sv
hdl/vector_distance_metric.sv
tb/vector_distance_metric_test.sv
